@@ src/pgb_pkg.sv @@
// pgb_pkg: shared widths, register indexes, side-band struct and the arctangent table
// for the polar point grid binning pipeline; used by every module of the block
`default_nettype none

package pgb_pkg;

    localparam int XYW   = 16;
    localparam int CONFW = 16;
    localparam int RSW   = 15;
    localparam int ASPW  = 16;
    localparam int CFGW  = 16;
    localparam int OUTW  = 6;

    // cordic x/y and angle widths, angle in units of 2^-32 rad
    localparam int XW = 36;
    localparam int ZW = 36;

    // column arithmetic widths
    localparam int PW  = 52;
    localparam int ASW = 50;
    localparam int MW  = 52;
    localparam int PIW = 35;

    // 180 degrees * 128 * 2
    localparam int DEG_SCALE = 46080;

    localparam logic [0:0] REG_RANGE_SPAN = 1'b0;
    localparam logic [0:0] REG_ANGLE_SPAN = 1'b1;

    typedef struct packed {
        logic [CONFW-1:0] conf;
        logic             first;
        logic             ok;
        logic             neg;
        logic             org;
    } side_t;

    // atan(2^-i) in units of 2^-32 rad, from integer series at 2^-60 then rounded
    function automatic logic [ZW-1:0] atan_entry(input int unsigned i);
        logic [63:0]  v;
        logic [63:0]  p;
        logic [63:0]  term;
        logic [63:0]  r;
        int unsigned  s;
        int unsigned  base;
        v    = 64'd0;
        base = (i == 0) ? 1 : i;
        for (int unsigned k = 0; k < 64; k++)
        begin
            s = base * (2 * k + 1);
            if (s < 60)
            begin
                term = (64'd1 << (60 - s)) / 64'(2 * k + 1);
                v    = k[0] ? v - term : v + term;
            end
        end
        if (i == 0)
        begin
            p = (64'd1 << 60) / 64'd3;
            for (int unsigned k = 0; k < 40; k++)
            begin
                if (p != 64'd0)
                begin
                    term = p / 64'(2 * k + 1);
                    v    = k[0] ? v - term : v + term;
                    p    = p / 64'd9;
                end
            end
        end
        r = (v + (64'd1 << 27)) >> 28;
        return r[ZW-1:0];
    endfunction

    localparam logic [ZW-1:0]        ATAN_ONE = atan_entry(0);
    localparam logic signed [ZW-1:0] HALF_PI  = ZW'({ATAN_ONE, 1'b0});
    localparam logic [PIW-1:0]       PI_Z     = PIW'({ATAN_ONE, 2'b00});

endpackage

`default_nettype wire

@@ src/pgb_rot_cell.sv @@
// pgb_rot_cell: one cell of the rotation chain, at most one cordic vectoring step and one
// square-root digit per cell, each enabled by a parameter; depends on pgb_pkg
`default_nettype none

module pgb_rot_cell #(
    parameter int IDX       = 0,
    parameter bit CORDIC_ON = 1'b1,
    parameter bit SQRT_ON   = 1'b1,
    parameter int RW        = 46
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             up_valid,
    input  wire logic signed [pgb_pkg::XW-1:0]    up_x,
    input  wire logic signed [pgb_pkg::XW-1:0]    up_y,
    input  wire logic signed [pgb_pkg::ZW-1:0]    up_z,
    input  wire logic [RW-1:0]                    up_rad,
    input  wire logic [RW/2:0]                    up_rem,
    input  wire logic [RW/2-1:0]                  up_root,
    input  wire pgb_pkg::side_t                   up_side,
    output logic                                  dn_valid,
    output logic signed [pgb_pkg::XW-1:0]         dn_x,
    output logic signed [pgb_pkg::XW-1:0]         dn_y,
    output logic signed [pgb_pkg::ZW-1:0]         dn_z,
    output logic [RW-1:0]                         dn_rad,
    output logic [RW/2:0]                         dn_rem,
    output logic [RW/2-1:0]                       dn_root,
    output pgb_pkg::side_t                        dn_side
);

    localparam int HW = RW / 2;
    localparam logic signed [pgb_pkg::ZW-1:0] ATAN_Z = pgb_pkg::atan_entry(IDX);

    logic                           valid_reg;
    logic signed [pgb_pkg::XW-1:0]  x_reg, x_next, dx;
    logic signed [pgb_pkg::XW-1:0]  y_reg, y_next, dy;
    logic signed [pgb_pkg::ZW-1:0]  z_reg, z_next;
    logic [RW-1:0]                  rad_reg, rad_next;
    logic [HW:0]                    rem_reg, rem_next;
    logic [HW-1:0]                  root_reg, root_next;
    pgb_pkg::side_t                 side_reg;
    logic [HW+2:0]                  cur, trial;
    logic                           ge;

    always_comb
    begin
        dx = up_y >>> IDX;
        dy = up_x >>> IDX;
        if (!CORDIC_ON)
        begin
            x_next = up_x;
            y_next = up_y;
            z_next = up_z;
        end
        else if (!up_y[pgb_pkg::XW-1])
        begin
            x_next = up_x + dx;
            y_next = up_y - dy;
            z_next = up_z + ATAN_Z;
        end
        else
        begin
            x_next = up_x - dx;
            y_next = up_y + dy;
            z_next = up_z - ATAN_Z;
        end

        cur   = {up_rem, up_rad[RW-1:RW-2]};
        trial = {1'b0, up_root, 2'b01};
        ge    = (cur >= trial);
        if (SQRT_ON)
        begin
            rad_next  = up_rad << 2;
            rem_next  = (HW+1)'(ge ? cur - trial : cur);
            root_next = {up_root[HW-2:0], ge};
        end
        else
        begin
            rad_next  = up_rad;
            rem_next  = up_rem;
            root_next = up_root;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= up_side;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;
    assign dn_z     = z_reg;
    assign dn_rad   = rad_reg;
    assign dn_rem   = rem_reg;
    assign dn_root  = root_reg;
    assign dn_side  = side_reg;

endmodule

`default_nettype wire

@@ src/pgb_div_cell.sv @@
// pgb_div_cell: one cell of the divider chain, one quotient bit of the row and one of
// the column per cell; depends on pgb_pkg
`default_nettype none

module pgb_div_cell #(
    parameter int RREMW = 24,
    parameter int RDIVW = 16,
    parameter int CREMW = 60,
    parameter int CDIVW = 52,
    parameter int QW    = 7,
    parameter int SH    = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              up_valid,
    input  wire logic [RREMW-1:0]  up_rrem,
    input  wire logic [RDIVW-1:0]  up_rdiv,
    input  wire logic [QW-1:0]     up_rq,
    input  wire logic [CREMW-1:0]  up_crem,
    input  wire logic [CDIVW-1:0]  up_cdiv,
    input  wire logic [QW-1:0]     up_cq,
    input  wire pgb_pkg::side_t    up_side,
    output logic                   dn_valid,
    output logic [RREMW-1:0]       dn_rrem,
    output logic [RDIVW-1:0]       dn_rdiv,
    output logic [QW-1:0]          dn_rq,
    output logic [CREMW-1:0]       dn_crem,
    output logic [CDIVW-1:0]       dn_cdiv,
    output logic [QW-1:0]          dn_cq,
    output pgb_pkg::side_t         dn_side
);

    localparam int RCW = RREMW + RDIVW;
    localparam int CCW = CREMW + CDIVW;

    logic                  valid_reg;
    logic [RREMW-1:0]      rrem_reg, rrem_next;
    logic [RDIVW-1:0]      rdiv_reg;
    logic [QW-1:0]         rq_reg, rq_next;
    logic [CREMW-1:0]      crem_reg, crem_next;
    logic [CDIVW-1:0]      cdiv_reg;
    logic [QW-1:0]         cq_reg, cq_next;
    pgb_pkg::side_t        side_reg;
    logic [RCW-1:0]        rsh;
    logic [CCW-1:0]        csh;
    logic                  rge, cge;

    always_comb
    begin
        rsh       = RCW'(up_rdiv) << SH;
        rge       = (RCW'(up_rrem) >= rsh);
        rrem_next = rge ? RREMW'(RCW'(up_rrem) - rsh) : up_rrem;
        rq_next   = up_rq;
        rq_next[SH] = rge;

        csh       = CCW'(up_cdiv) << SH;
        cge       = (CCW'(up_crem) >= csh);
        crem_next = cge ? CREMW'(CCW'(up_crem) - csh) : up_crem;
        cq_next   = up_cq;
        cq_next[SH] = cge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rrem_reg <= rrem_next;
            rdiv_reg <= up_rdiv;
            rq_reg   <= rq_next;
            crem_reg <= crem_next;
            cdiv_reg <= up_cdiv;
            cq_reg   <= cq_next;
            side_reg <= up_side;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rrem  = rrem_reg;
    assign dn_rdiv  = rdiv_reg;
    assign dn_rq    = rq_reg;
    assign dn_crem  = crem_reg;
    assign dn_cdiv  = cdiv_reg;
    assign dn_cq    = cq_reg;
    assign dn_side  = side_reg;

endmodule

`default_nettype wire

@@ src/polar_point_grid_binning.sv @@
// polar_point_grid_binning: maps detected points to cells of a polar grid
// depends on pgb_pkg, pgb_rot_cell and pgb_div_cell
//
// usage
//   config port: cfg_write with cfg_index 0 (range_span) or 1 (angle_span) and cfg_data;
//   taken at the clock edge, write only while no point is in flight
//   input channel: in_valid/in_ready carry point_x, point_y, confidence, first_of_scan
//   output channel: out_valid/out_ready carry cell_row, cell_col, cell_value, in_frame,
//   clear_grid; one result per point, in order
//   throughput: one point per clock when the output is not stalled; the whole path is a
//   chain of registered cells: the front stage, the range-square stage, the rotation
//   cells, the column numerator, sign-magnitude and scaling stages, the divider cells and
//   the output register; with the defaults its length is set by the square-root cells and the divider cells
//   when out_ready is low with a result waiting, the whole chain holds and in_ready drops;
//   bubbles in the chain are not squeezed out
//   reset empties the chain and loads range_span 2560 and angle_span 23040
`default_nettype none

module polar_point_grid_binning #(
    parameter int GRID_ROWS     = 64,
    parameter int GRID_COLS     = 64,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [0:0]                        cfg_index,
    input  wire logic [pgb_pkg::CFGW-1:0]          cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [pgb_pkg::XYW-1:0]    point_x,
    input  wire logic signed [pgb_pkg::XYW-1:0]    point_y,
    input  wire logic [pgb_pkg::CONFW-1:0]         confidence,
    input  wire logic                              first_of_scan,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [pgb_pkg::OUTW-1:0]               cell_row,
    output logic [pgb_pkg::OUTW-1:0]               cell_col,
    output logic [pgb_pkg::CONFW-1:0]              cell_value,
    output logic                                   in_frame,
    output logic                                   clear_grid
);

    localparam int RB  = $clog2(GRID_ROWS);
    localparam int CB  = $clog2(GRID_COLS);
    localparam int HW  = RB + 17;
    localparam int RW  = 2 * HW;
    localparam int NC  = (CORDIC_STAGES > HW) ? CORDIC_STAGES : HW;
    localparam int QP  = (RB > CB) ? RB : CB;
    localparam int QW  = QP + 1;
    localparam int RTW = HW + 1;
    localparam int RDW = pgb_pkg::RSW + 1;
    localparam int TW  = pgb_pkg::MW + CB + 2;
    localparam int DW  = pgb_pkg::ASW + 2;
    localparam logic [RW-1:0] RAD_K = RW'(4 * GRID_ROWS * GRID_ROWS);

    localparam int XW = pgb_pkg::XW;
    localparam int ZW = pgb_pkg::ZW;
    localparam int PW = pgb_pkg::PW;

    logic adv;

    // configuration registers
    logic [pgb_pkg::RSW-1:0]  range_span_reg;
    logic [pgb_pkg::ASPW-1:0] angle_span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_span_reg <= pgb_pkg::RSW'(2560);
            angle_span_reg <= pgb_pkg::ASPW'(23040);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pgb_pkg::REG_RANGE_SPAN: range_span_reg <= cfg_data[pgb_pkg::RSW-1:0];
                pgb_pkg::REG_ANGLE_SPAN: angle_span_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // front stage: squares, quarter turn, scaling
    logic signed [16:0]       xe, ye, xt, yt;
    logic signed [31:0]       xx, yy;
    logic signed [XW-1:0]     f_x_next, f_y_next;
    logic signed [ZW-1:0]     f_z_next;
    logic [31:0]              f_q_next;
    pgb_pkg::side_t           f_side_next;

    logic                     f_valid_reg;
    logic signed [XW-1:0]     f_x_reg, f_y_reg;
    logic signed [ZW-1:0]     f_z_reg;
    logic [31:0]              f_q_reg;
    pgb_pkg::side_t           f_side_reg;

    always_comb
    begin
        xe = {point_x[pgb_pkg::XYW-1], point_x};
        ye = {point_y[pgb_pkg::XYW-1], point_y};
        xx = point_x * point_x;
        yy = point_y * point_y;
        f_q_next = $unsigned(xx) + $unsigned(yy);
        if (!point_x[pgb_pkg::XYW-1])
        begin
            xt       = xe;
            yt       = ye;
            f_z_next = '0;
        end
        else if (!point_y[pgb_pkg::XYW-1])
        begin
            xt       = ye;
            yt       = -xe;
            f_z_next = pgb_pkg::HALF_PI;
        end
        else
        begin
            xt       = -ye;
            yt       = xe;
            f_z_next = -pgb_pkg::HALF_PI;
        end
        f_x_next = {{(XW-33){xt[16]}}, xt, 16'h0000};
        f_y_next = {{(XW-33){yt[16]}}, yt, 16'h0000};
        f_side_next.conf  = confidence;
        f_side_next.first = first_of_scan;
        f_side_next.ok    = (range_span_reg != '0) && (angle_span_reg != '0);
        f_side_next.neg   = 1'b0;
        f_side_next.org   = (point_x == '0) && (point_y == '0);
    end

    // second stage: scaled range square
    logic                     g_valid_reg;
    logic signed [XW-1:0]     g_x_reg, g_y_reg;
    logic signed [ZW-1:0]     g_z_reg;
    logic [RW-1:0]            g_rad_reg;
    pgb_pkg::side_t           g_side_reg;

    // rotation chain
    logic                     rv    [0:NC];
    logic signed [XW-1:0]     rx    [0:NC];
    logic signed [XW-1:0]     ry    [0:NC];
    logic signed [ZW-1:0]     rz    [0:NC];
    logic [RW-1:0]            rrad  [0:NC];
    logic [HW:0]              rrem  [0:NC];
    logic [HW-1:0]            rroot [0:NC];
    pgb_pkg::side_t           rside [0:NC];

    assign rv[0]    = g_valid_reg;
    assign rx[0]    = g_x_reg;
    assign ry[0]    = g_y_reg;
    assign rz[0]    = g_z_reg;
    assign rrad[0]  = g_rad_reg;
    assign rrem[0]  = '0;
    assign rroot[0] = '0;
    assign rside[0] = g_side_reg;

    for (genvar i = 0; i < NC; i++)
    begin : g_rot
        pgb_rot_cell #(
            .IDX       (i),
            .CORDIC_ON (i < CORDIC_STAGES),
            .SQRT_ON   (i < HW),
            .RW        (RW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .up_valid (rv[i]),
            .up_x     (rx[i]),
            .up_y     (ry[i]),
            .up_z     (rz[i]),
            .up_rad   (rrad[i]),
            .up_rem   (rrem[i]),
            .up_root  (rroot[i]),
            .up_side  (rside[i]),
            .dn_valid (rv[i+1]),
            .dn_x     (rx[i+1]),
            .dn_y     (ry[i+1]),
            .dn_z     (rz[i+1]),
            .dn_rad   (rrad[i+1]),
            .dn_rem   (rrem[i+1]),
            .dn_root  (rroot[i+1]),
            .dn_side  (rside[i+1])
        );
    end

    // column numerator terms and row numerator
    logic signed [ZW-1:0]         phi;
    logic signed [PW-1:0]         h_p1_next;
    logic                         h_valid_reg;
    logic signed [PW-1:0]         h_p1_reg;
    logic [pgb_pkg::ASW-1:0]      h_as_reg;
    logic [RTW-1:0]               h_rt_reg;
    logic [RDW-1:0]               h_rd_reg;
    pgb_pkg::side_t               h_side_reg;

    assign phi       = rside[NC].org ? '0 : rz[NC];
    assign h_p1_next = PW'(phi) * PW'(pgb_pkg::DEG_SCALE);

    // signed numerator to sign and magnitude
    logic signed [PW:0]           n0;
    logic                         i_valid_reg;
    logic [pgb_pkg::MW-1:0]       i_mag_reg;
    logic [pgb_pkg::ASW-1:0]      i_as_reg;
    logic [RTW-1:0]               i_rt_reg;
    logic [RDW-1:0]               i_rd_reg;
    pgb_pkg::side_t               i_side_reg;
    pgb_pkg::side_t               i_side_next;

    always_comb
    begin
        n0 = {h_p1_reg[PW-1], h_p1_reg} + {{(PW+1-pgb_pkg::ASW){1'b0}}, h_as_reg};
        i_side_next     = h_side_reg;
        i_side_next.neg = n0[PW];
    end

    // scaled dividend and divisor of the column
    logic [TW-1:0]                magc;
    logic                         j_valid_reg;
    logic [TW-1:0]                j_t_reg;
    logic [DW-1:0]                j_cd_reg;
    logic [RTW-1:0]               j_rt_reg;
    logic [RDW-1:0]               j_rd_reg;
    pgb_pkg::side_t               j_side_reg;

    assign magc = TW'(i_mag_reg) * TW'(GRID_COLS);

    // divider chain
    logic                     dv    [0:QW];
    logic [RTW-1:0]           drr   [0:QW];
    logic [RDW-1:0]           drd   [0:QW];
    logic [QW-1:0]            drq   [0:QW];
    logic [TW-1:0]            dcr   [0:QW];
    logic [DW-1:0]            dcd   [0:QW];
    logic [QW-1:0]            dcq   [0:QW];
    pgb_pkg::side_t           dside [0:QW];

    assign dv[0]    = j_valid_reg;
    assign drr[0]   = j_rt_reg;
    assign drd[0]   = j_rd_reg;
    assign drq[0]   = '0;
    assign dcr[0]   = j_t_reg;
    assign dcd[0]   = j_cd_reg;
    assign dcq[0]   = '0;
    assign dside[0] = j_side_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        pgb_div_cell #(
            .RREMW (RTW),
            .RDIVW (RDW),
            .CREMW (TW),
            .CDIVW (DW),
            .QW    (QW),
            .SH    (QP - j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .up_valid (dv[j]),
            .up_rrem  (drr[j]),
            .up_rdiv  (drd[j]),
            .up_rq    (drq[j]),
            .up_crem  (dcr[j]),
            .up_cdiv  (dcd[j]),
            .up_cq    (dcq[j]),
            .up_side  (dside[j]),
            .dn_valid (dv[j+1]),
            .dn_rrem  (drr[j+1]),
            .dn_rdiv  (drd[j+1]),
            .dn_rq    (drq[j+1]),
            .dn_crem  (dcr[j+1]),
            .dn_cdiv  (dcd[j+1]),
            .dn_cq    (dcq[j+1]),
            .dn_side  (dside[j+1])
        );
    end

    // output register
    logic                         frame_next;
    logic                         out_valid_reg;
    logic [pgb_pkg::OUTW-1:0]     out_row_reg;
    logic [pgb_pkg::OUTW-1:0]     out_col_reg;
    logic [pgb_pkg::CONFW-1:0]    out_value_reg;
    logic                         out_frame_reg;
    logic                         out_clear_reg;

    assign frame_next = dside[QW].ok
                        && (drq[QW] < QW'(GRID_ROWS))
                        && (dcq[QW] < QW'(GRID_COLS))
                        && !(dside[QW].neg && (dcq[QW] != '0));

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg   <= 1'b0;
            g_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            i_valid_reg   <= 1'b0;
            j_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg   <= in_valid;
            g_valid_reg   <= f_valid_reg;
            h_valid_reg   <= rv[NC];
            i_valid_reg   <= h_valid_reg;
            j_valid_reg   <= i_valid_reg;
            out_valid_reg <= dv[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_x_reg    <= f_x_next;
            f_y_reg    <= f_y_next;
            f_z_reg    <= f_z_next;
            f_q_reg    <= f_q_next;
            f_side_reg <= f_side_next;

            g_x_reg    <= f_x_reg;
            g_y_reg    <= f_y_reg;
            g_z_reg    <= f_z_reg;
            g_rad_reg  <= RW'(f_q_reg * RAD_K);
            g_side_reg <= f_side_reg;

            h_p1_reg   <= h_p1_next;
            h_as_reg   <= pgb_pkg::ASW'(pgb_pkg::PI_Z) * pgb_pkg::ASW'(angle_span_reg);
            h_rt_reg   <= RTW'(rroot[NC]) + RTW'(range_span_reg);
            h_rd_reg   <= {range_span_reg, 1'b0};
            h_side_reg <= rside[NC];

            i_mag_reg  <= pgb_pkg::MW'(n0[PW] ? -n0 : n0);
            i_as_reg   <= h_as_reg;
            i_rt_reg   <= h_rt_reg;
            i_rd_reg   <= h_rd_reg;
            i_side_reg <= i_side_next;

            j_t_reg    <= (magc << 1) + (TW'(i_as_reg) << 1);
            j_cd_reg   <= {i_as_reg, 2'b00};
            j_rt_reg   <= i_rt_reg;
            j_rd_reg   <= i_rd_reg;
            j_side_reg <= i_side_reg;

            out_row_reg   <= frame_next ? pgb_pkg::OUTW'(drq[QW]) : '0;
            out_col_reg   <= frame_next ? pgb_pkg::OUTW'(dcq[QW]) : '0;
            out_value_reg <= frame_next ? dside[QW].conf : '0;
            out_frame_reg <= frame_next;
            out_clear_reg <= dside[QW].first;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_row   = out_row_reg;
    assign cell_col   = out_col_reg;
    assign cell_value = out_value_reg;
    assign in_frame   = out_frame_reg;
    assign clear_grid = out_clear_reg;

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_frame) |-> (cell_row == '0 && cell_col == '0 && cell_value == '0))
        else $error("out-of-frame result carries nonzero cell fields");

    a_rise_needs_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("result appeared while the chain was held");

    a_stall_holds_front: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(f_valid_reg))
        else $error("front stage moved during an output stall");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for polar_point_grid_binning
// depends on pgb_pkg and the block's rtl; predicts every cell with its own
// integer model of the range, the cordic bearing and the rounding
`default_nettype none

module tb_top;

    localparam int ROWS = 64;
    localparam int COLS = 64;
    localparam int STAGES = 16;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [pgb_pkg::OUTW-1:0]  row;
        logic [pgb_pkg::OUTW-1:0]  col;
        logic [pgb_pkg::CONFW-1:0] value;
        logic                      framed;
        logic                      clear;
    } cell_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_write = 1'b0;
    logic [0:0]                       cfg_index = pgb_pkg::REG_RANGE_SPAN;
    logic [pgb_pkg::CFGW-1:0]         cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic signed [pgb_pkg::XYW-1:0]   point_x = '0;
    logic signed [pgb_pkg::XYW-1:0]   point_y = '0;
    logic [pgb_pkg::CONFW-1:0]        confidence = '0;
    logic                             first_of_scan = 1'b0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [pgb_pkg::OUTW-1:0]         cell_row;
    logic [pgb_pkg::OUTW-1:0]         cell_col;
    logic [pgb_pkg::CONFW-1:0]        cell_value;
    logic                             in_frame;
    logic                             clear_grid;

    longint   atan_tab [STAGES];
    longint   range_span_q;
    longint   angle_span_q;
    cell_t    pending_cells [$];
    int       errors = 0;
    int       points_sent = 0;
    int       cells_seen = 0;
    int       framed_seen = 0;
    bit       no_idle = 1'b0;

    polar_point_grid_binning DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .point_x(point_x), .point_y(point_y), .confidence(confidence),
        .first_of_scan(first_of_scan),
        .out_valid(out_valid), .out_ready(out_ready),
        .cell_row(cell_row), .cell_col(cell_col), .cell_value(cell_value),
        .in_frame(in_frame), .clear_grid(clear_grid)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint atan_series(int unsigned i);
        longint sum;
        int unsigned s;
        sum = 0;
        for (int unsigned k = 0; k < 64; k++)
        begin
            s = i * (2 * k + 1);
            if (s < 60)
                sum = k[0] ? sum - ((64'sd1 <<< (60 - s)) / (2 * k + 1))
                           : sum + ((64'sd1 <<< (60 - s)) / (2 * k + 1));
        end
        return sum;
    endfunction

    function automatic longint atan_third();
        longint p;
        longint sum;
        int unsigned k;
        p = (64'sd1 <<< 60) / 3;
        sum = 0;
        k = 0;
        while (p != 0)
        begin
            sum = k[0] ? sum - p / (2 * k + 1) : sum + p / (2 * k + 1);
            p = p / 9;
            k++;
        end
        return sum;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 60;
        while (b > n)
            b = b >>> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >>> 1) + b;
            end
            else
                res = res >>> 1;
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic longint bearing_angle(longint x, longint y);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = y; y = -x; x = t; z = 2 * atan_tab[0];
            end
            else
            begin
                t = -y; y = x; x = t; z = -2 * atan_tab[0];
            end
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end
        end
        return z;
    endfunction

    function automatic cell_t bin_point(logic signed [pgb_pkg::XYW-1:0] px,
                                        logic signed [pgb_pkg::XYW-1:0] py,
                                        logic [pgb_pkg::CONFW-1:0] cf, logic fs);
        cell_t  c;
        longint x;
        longint y;
        longint m;
        longint phi;
        longint n;
        longint d;
        longint mag;
        longint col;
        longint row;
        bit     ok;
        x = longint'(px);
        y = longint'(py);
        row = 0;
        col = 0;
        ok = (range_span_q != 0) && (angle_span_q != 0);
        if (ok)
        begin
            m = int_sqrt(4 * ROWS * ROWS * (x * x + y * y));
            phi = bearing_angle(x, y);
            n = (phi * 46080 + 4 * atan_tab[0] * angle_span_q) * COLS;
            d = 8 * atan_tab[0] * angle_span_q;
            mag = (n < 0) ? -n : n;
            col = (2 * mag + d) / (2 * d);
            row = (m + range_span_q) / (2 * range_span_q);
            if (n < 0 && col != 0)
                ok = 1'b0;
            if (row >= ROWS || col >= COLS)
                ok = 1'b0;
        end
        c.row = ok ? row[pgb_pkg::OUTW-1:0] : '0;
        c.col = ok ? col[pgb_pkg::OUTW-1:0] : '0;
        c.value = ok ? cf : '0;
        c.framed = ok;
        c.clear = fs;
        return c;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s: got %0d, want %0d (cell %0d)", field, got, want, cells_seen);
        errors++;
    endtask

    // result side: stall per transfer, check just before the transfer edge
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            w = no_idle ? 0 : $urandom_range(0, 13);
            if (w > 0)
            begin
                @(posedge clk);
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            else
                @(posedge clk);
            out_ready <= 1'b1;
            do @(negedge clk); while (!(out_valid && out_ready));
        end
    end

    always @(negedge clk)
    begin
        cell_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cells.size() == 0)
                report_mismatch("extra cell", longint'(cells_seen), longint'(points_sent));
            else
            begin
                e = pending_cells.pop_front();
                if (cell_row !== e.row)
                    report_mismatch("cell_row", longint'(cell_row), longint'(e.row));
                if (cell_col !== e.col)
                    report_mismatch("cell_col", longint'(cell_col), longint'(e.col));
                if (cell_value !== e.value)
                    report_mismatch("cell_value", longint'(cell_value), longint'(e.value));
                if (in_frame !== e.framed)
                    report_mismatch("in_frame", longint'(in_frame), longint'(e.framed));
                if (clear_grid !== e.clear)
                    report_mismatch("clear_grid", longint'(clear_grid), longint'(e.clear));
                if (e.framed) framed_seen++;
            end
            cells_seen++;
        end
    end

    task automatic send_point(logic signed [pgb_pkg::XYW-1:0] px,
                              logic signed [pgb_pkg::XYW-1:0] py,
                              logic [pgb_pkg::CONFW-1:0] cf, logic fs);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x <= px;
        point_y <= py;
        confidence <= cf;
        first_of_scan <= fs;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        pending_cells.push_back(bin_point(px, py, cf, fs));
        points_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [pgb_pkg::CFGW-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == pgb_pkg::REG_RANGE_SPAN)
            range_span_q = longint'(val[pgb_pkg::RSW-1:0]);
        else
            angle_span_q = longint'(val[pgb_pkg::ASPW-1:0]);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_spans(logic [pgb_pkg::CFGW-1:0] rs, logic [pgb_pkg::CFGW-1:0] as);
        drain();
        write_reg(pgb_pkg::REG_RANGE_SPAN, rs);
        write_reg(pgb_pkg::REG_ANGLE_SPAN, as);
    endtask

    task automatic random_point(int span_hint);
        logic signed [pgb_pkg::XYW-1:0] px;
        logic signed [pgb_pkg::XYW-1:0] py;
        int lim;
        case ($urandom_range(0, 3))
            0:
            begin
                px = pgb_pkg::XYW'($urandom);
                py = pgb_pkg::XYW'($urandom);
            end
            1:
            begin
                lim = (span_hint < 1) ? 1 : span_hint;
                px = pgb_pkg::XYW'($urandom_range(0, 2 * lim) - lim);
                py = pgb_pkg::XYW'($urandom_range(0, 2 * lim) - lim);
            end
            2:
            begin
                px = $urandom_range(0, 1) ? pgb_pkg::XYW'($urandom) : '0;
                py = (px == 0) ? pgb_pkg::XYW'($urandom) : '0;
            end
            default:
            begin
                px = pgb_pkg::XYW'($urandom_range(0, 512) - 256);
                py = pgb_pkg::XYW'($urandom_range(0, 512) - 256);
            end
        endcase
        send_point(px, py, pgb_pkg::CONFW'($urandom), ($urandom_range(0, 15) == 0));
    endtask

    task automatic test_directed_reset_spans();
        send_point(16'sd0, 16'sd0, 16'hffff, 1'b1);
        send_point(16'sd32767, 16'sd32767, 16'h0000, 1'b0);
        send_point(-16'sd32768, -16'sd32768, 16'hffff, 1'b0);
        send_point(-16'sd32768, 16'sd0, 16'h1234, 1'b0);
        send_point(16'sd0, 16'sd32767, 16'h8000, 1'b1);
        send_point(16'sd0, -16'sd32768, 16'h0001, 1'b0);
        send_point(16'sd256, 16'sd0, 16'h5555, 1'b0);
        send_point(16'sd256, -16'sd256, 16'haaaa, 1'b0);
        send_point(-16'sd256, 16'sd1, 16'h7fff, 1'b0);
        send_point(-16'sd256, -16'sd1, 16'hfffe, 1'b0);
        send_point(16'sd1, -16'sd1, 16'h00ff, 1'b0);
        send_point(16'sd2560, 16'sd0, 16'hff00, 1'b1);
    endtask

    task automatic test_directed_extreme_spans();
        set_spans(16'd32767, 16'd46080);
        send_point(16'sd32767, 16'sd0, 16'hffff, 1'b0);
        send_point(-16'sd32768, 16'sd1, 16'h0f0f, 1'b1);
        send_point(-16'sd32768, -16'sd1, 16'hf0f0, 1'b0);
        set_spans(16'd1, 16'd1);
        send_point(16'sd1, 16'sd0, 16'hffff, 1'b0);
        send_point(16'sd0, 16'sd0, 16'h4321, 1'b1);
        send_point(16'sd100, -16'sd1, 16'h0101, 1'b0);
        set_spans(16'h8000, 16'd0);
        send_point(16'sd0, 16'sd0, 16'hffff, 1'b1);
        send_point(16'sd10, 16'sd10, 16'hffff, 1'b0);
    endtask

    task automatic test_random_phase(logic [pgb_pkg::CFGW-1:0] rs,
                                     logic [pgb_pkg::CFGW-1:0] as, int count);
        set_spans(rs, as);
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 30)
                no_idle = ~no_idle;
            random_point(int'(rs[pgb_pkg::RSW-1:0]));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_pause_until_empty();
        for (int i = 0; i < 40; i++)
        begin
            random_point(2560);
            if (i == 20)
            begin
                in_valid <= 1'b0;
                while (pending_cells.size() != 0) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < STAGES; i++)
            atan_tab[i] = (((i == 0) ? atan_series(1) + atan_third() : atan_series(i))
                           + (64'sd1 <<< 27)) >>> 28;
        range_span_q = 2560;
        angle_span_q = 23040;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_reset_spans();
        test_directed_extreme_spans();
        test_random_phase(16'd2560, 16'd23040, 160);
        test_pause_until_empty();
        test_random_phase(16'd32767, 16'd46080, 100);
        test_random_phase(16'd1, 16'd1, 60);
        test_random_phase(pgb_pkg::CFGW'($urandom_range(1, 32767)),
                          pgb_pkg::CFGW'($urandom_range(1, 46080)), 120);
        test_random_phase(pgb_pkg::CFGW'($urandom_range(1, 4096)),
                          pgb_pkg::CFGW'($urandom_range(1, 2000)), 120);
        test_random_phase(16'd0, pgb_pkg::CFGW'($urandom_range(1, 46080)), 20);
        test_random_phase(pgb_pkg::CFGW'($urandom_range(1, 32767)), 16'd0, 20);
        drain();
        $display("%0d points sent over spans from zero to full scale, %0d cells checked",
                 points_sent, cells_seen);
        $display("%0d cells in frame, with random stalls on both channels", framed_seen);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
src/pgb_pkg.sv
src/pgb_rot_cell.sv
src/pgb_div_cell.sv
src/polar_point_grid_binning.sv
tb/tb_top.sv
